// ----- rtl/core/lscd_pkg.sv -----
// Shared types, constants and helpers for the limited-stock change dispenser.
// Depends on nothing; imported by lscd_div and limited_stock_change_dispenser.
`timescale 1ns / 1ps

package lscd_pkg;

    localparam int NUM_COINS      = 6;
    localparam int AMOUNT_BITS    = 16;
    localparam int SLOT_BITS      = 10;
    localparam int PACK_BITS      = 6 * SLOT_BITS;
    localparam int SLOT_IDX_BITS  = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
    localparam int DIV_CNT_BITS   = $clog2(AMOUNT_BITS + 1);
    localparam int PROD_BITS      = 2 * SLOT_BITS;
    localparam int QCMP_BITS      = (AMOUNT_BITS > SLOT_BITS) ? AMOUNT_BITS : SLOT_BITS;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_COIN_VALUES = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_COIN_STOCKS = CFG_INDEX_BITS'(1);

    localparam logic [SLOT_IDX_BITS-1:0] LAST_SLOT = SLOT_IDX_BITS'(NUM_COINS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_MUL,
        ST_SUB,
        ST_EMIT
    } lscd_state_t;

    typedef struct packed {
        logic                   start;
        logic [AMOUNT_BITS-1:0] dividend;
        logic [SLOT_BITS-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [AMOUNT_BITS-1:0] quotient;
    } div_rsp_t;

    // Pick one 10-bit slot out of a packed register.
    function automatic logic [SLOT_BITS-1:0] slot_field(
        input logic [PACK_BITS-1:0]     packed_reg,
        input logic [SLOT_IDX_BITS-1:0] idx
    );
        slot_field = packed_reg[idx * SLOT_BITS +: SLOT_BITS];
    endfunction

endpackage

// ----- rtl/core/limited_stock_change_dispenser.sv -----
// After the input beat the sequencer divides, multiplies back and subtracts for each
// slot, top slot first, then gives one result beat per cycle while out_ready.
// A new request is taken only after the last result beat of the one before; the
// shared bit-serial divider, one quotient bit per cycle for each of the six slots,
// sets the pace of each request.
// Reset: asynchronous, active low; clears the sequencer and both configuration
// registers, after which in_ready is high.
`timescale 1ns / 1ps

module limited_stock_change_dispenser
    import lscd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Request channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [AMOUNT_BITS-1:0]    amount_paid,
    input  logic [AMOUNT_BITS-1:0]    item_price,
    // Result channel, one beat per coin slot, slot 0 first
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [SLOT_BITS-1:0]      coin_value,
    output logic [SLOT_BITS-1:0]      coin_count,
    output logic                      shortfall,
    output logic                      last_coin,
    // Configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PACK_BITS-1:0]      cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while idle; the
    // block does not enforce it, accepts every beat, and drops unknown indexes.
    // ------------------------------------------------------------------
    logic [PACK_BITS-1:0] coin_values_reg;
    logic [PACK_BITS-1:0] coin_stocks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coin_values_reg <= '0;
            coin_stocks_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COIN_VALUES: coin_values_reg <= cfg_data;
                REG_COIN_STOCKS: coin_stocks_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers.
    // slot_reg walks from the top slot down during the divides, then is
    // reused as the emit index walking back up from slot 0.
    // ------------------------------------------------------------------
    lscd_state_t              state_reg;
    lscd_state_t              state_next;
    logic [SLOT_IDX_BITS-1:0] slot_reg;
    logic [AMOUNT_BITS-1:0]   rem_reg;
    logic [SLOT_BITS-1:0]     cnt_reg;
    logic [PROD_BITS-1:0]     prod_reg;
    logic [SLOT_BITS-1:0]     slot_counts_reg [NUM_COINS];

    logic                     in_beat;
    logic                     out_beat;
    logic [SLOT_BITS-1:0]     cur_value;
    logic [SLOT_BITS-1:0]     cur_stock;
    logic [SLOT_BITS-1:0]     capped_cnt;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    assign in_beat   = in_valid && in_ready;
    assign out_beat  = out_valid && out_ready;
    assign cur_value = slot_field(coin_values_reg, slot_reg);
    assign cur_stock = slot_field(coin_stocks_reg, slot_reg);

    // Cap the quotient at the slot's stock; a zero denomination gives nothing.
    always_comb
    begin
        if (cur_value == '0)
            capped_cnt = '0;
        else if (QCMP_BITS'(div_rsp.quotient) > QCMP_BITS'(cur_stock))
            capped_cnt = cur_stock;
        else
            capped_cnt = div_rsp.quotient[SLOT_BITS-1:0];
    end

    // Shared divider: remaining change over the current denomination.
    lscd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_beat) state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:   if (div_rsp.done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUB;
            ST_SUB:   state_next = (slot_reg == '0) ? ST_EMIT : ST_START;
            ST_EMIT:  if (out_beat && slot_reg == LAST_SLOT) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_ready         = 1'b0;
        out_valid        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = rem_reg;
        div_req.divisor  = cur_value;
        unique case (state_reg)
            ST_IDLE:  in_ready      = 1'b1;
            ST_START: div_req.start = 1'b1;
            ST_EMIT:  out_valid     = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    // Change owed, clamped at zero when underpaid.
                    if (in_beat)
                    begin
                        rem_reg  <= (amount_paid > item_price) ? amount_paid - item_price : '0;
                        slot_reg <= LAST_SLOT;
                    end
                end
                ST_SUB:
                begin
                    // prod never exceeds the remainder, so the narrow subtract is exact.
                    rem_reg <= rem_reg - AMOUNT_BITS'(prod_reg);
                    if (slot_reg != '0)
                        slot_reg <= slot_reg - 1'b1;
                end
                ST_EMIT:
                begin
                    if (out_beat && slot_reg != LAST_SLOT)
                        slot_reg <= slot_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Count capture, product and per-slot count store: payload, no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV && div_rsp.done)
            cnt_reg <= capped_cnt;
        if (state_reg == ST_MUL)
        begin
            prod_reg                  <= cnt_reg * cur_value;
            slot_counts_reg[slot_reg] <= cnt_reg;
        end
    end

    // Result beat: fields held from registers while out_valid waits.
    assign coin_value = cur_value;
    assign coin_count = slot_counts_reg[slot_reg];
    assign shortfall  = rem_reg != '0;
    assign last_coin  = slot_reg == LAST_SLOT;

`ifndef SYNTHESIS
    // Request and result channels are never open at the same time.
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("in_ready and out_valid high together");

    // An accepted request always starts the divide sequence at the top slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_START && slot_reg == LAST_SLOT))
        else $error("request did not start at the top slot");

    // The divider only reports completion while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n) div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider done outside divide wait");
`endif

endmodule

// ----- rtl/core/lscd_div.sv -----
// Restoring divider, one quotient bit per cycle while busy, AMOUNT_BITS quotient bits per divide.
// Depends on lscd_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module lscd_div
    import lscd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [SLOT_BITS-1:0]    part_reg;
    logic [SLOT_BITS-1:0]    divisor_reg;
    logic [AMOUNT_BITS-1:0]  quo_reg;

    logic [SLOT_BITS:0]      trial;
    logic [SLOT_BITS:0]      diff;
    logic                    ge;

    assign trial = {part_reg, quo_reg[AMOUNT_BITS-1]};
    assign ge    = trial >= {1'b0, divisor_reg};
    assign diff  = trial - {1'b0, divisor_reg};

    // Control: count down the quotient bits, pulse done at the end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(AMOUNT_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the dividend out, the quotient in.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            part_reg    <= '0;
            divisor_reg <= req.divisor;
            quo_reg     <= req.dividend;
        end
        else if (busy_reg)
        begin
            part_reg <= ge ? diff[SLOT_BITS-1:0] : trial[SLOT_BITS-1:0];
            quo_reg  <= {quo_reg[AMOUNT_BITS-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
